>>> rtl/fault_rate_escalator_core_macros.svh
// Assertion helpers used by the RTL of the fault rate escalator core.
`ifndef FAULT_RATE_ESCALATOR_CORE_MACROS_SVH
`define FAULT_RATE_ESCALATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fre_pkg.sv
`default_nettype none

package fre_pkg;

   // Fixed sizes of the block.
   localparam int FaultKinds = 10;
   localparam int KindBits   = 4;
   localparam int TimeBits   = 32;
   localparam int RecentBits = 16;
   localparam int TotalBits  = 32;
   localparam int WakeBits   = 16;
   localparam int RuleBits   = 16;

   // Request kinds.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_RAISE = 1'b1;

   // Escalation actions.
   typedef enum logic [2:0] {
      ACT_IGNORE  = 3'd0,
      ACT_SOFT    = 3'd1,
      ACT_FEED    = 3'd2,
      ACT_HARD    = 3'd3,
      ACT_OBSERVE = 3'd4
   } action_type;

   // One rule of the fixed rule table.
   typedef struct packed {
      action_type          first;
      logic [RuleBits-1:0] window;
      logic [RuleBits-1:0] threshold;
      action_type          escalated;
   } rule_type;

   // Per-kind state word held in the state memory.
   typedef struct packed {
      logic [TimeBits-1:0]   window_start;
      logic [RecentBits-1:0] recent;
      logic [TotalBits-1:0]  total;
      action_type            last_action;
   } entry_type;

   // Rule table lookup; kinds without a rule read as an all-zero rule.
   function automatic rule_type rule_lookup(input logic [KindBits-1:0] kind);
      rule_type r;
      r = '{ACT_IGNORE, RuleBits'(0), RuleBits'(0), ACT_IGNORE};
      unique case (kind)
         4'd0:    r = '{ACT_SOFT,    RuleBits'(60),  RuleBits'(3),  ACT_HARD};
         4'd1:    r = '{ACT_SOFT,    RuleBits'(60),  RuleBits'(5),  ACT_HARD};
         4'd2:    r = '{ACT_FEED,    RuleBits'(300), RuleBits'(5),  ACT_HARD};
         4'd3:    r = '{ACT_FEED,    RuleBits'(300), RuleBits'(3),  ACT_HARD};
         4'd4:    r = '{ACT_IGNORE,  RuleBits'(60),  RuleBits'(20), ACT_FEED};
         4'd5:    r = '{ACT_FEED,    RuleBits'(600), RuleBits'(3),  ACT_OBSERVE};
         4'd6:    r = '{ACT_FEED,    RuleBits'(300), RuleBits'(10), ACT_HARD};
         4'd7:    r = '{ACT_FEED,    RuleBits'(60),  RuleBits'(3),  ACT_HARD};
         4'd8:    r = '{ACT_IGNORE,  RuleBits'(60),  RuleBits'(3),  ACT_OBSERVE};
         4'd9:    r = '{ACT_OBSERVE, RuleBits'(0),   RuleBits'(0),  ACT_OBSERVE};
         default: r = '{ACT_IGNORE,  RuleBits'(0),   RuleBits'(0),  ACT_IGNORE};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/fault_rate_escalator_core.sv
`default_nettype none

`include "fault_rate_escalator_core_macros.svh"

// Fault rate escalator. A tick beat advances the time counter and
// gives no response; a raise beat for a known fault kind gives one response
// beat carrying the chosen action, the window and lifetime counts, the sticky
// observe flag and the configured wake value. Raises of unknown kinds are
// dropped silently. The per-kind state sits in a ten-entry synchronous memory:
// the accepting edge issues the read, and the edge on which the update stage
// advances updates the entry, writes it back and loads the response register.
// The response beat is therefore offered from the response register once the
// update stage has advanced. One request is taken every cycle as long as the
// response side keeps up; a stalled response holds the update stage and so
// stalls the request side. A raise that follows a raise of the same kind picks
// up the freshly written entry from the write port. Reset clears the memory at
// once through per-entry valid bits, with no clearing pass.
module fault_rate_escalator_core
   import fre_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [KindBits-1:0]   req_fault_id,
   // Response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [KindBits-1:0]        rsp_fault_kind,
   output logic [2:0]                 rsp_action,
   output logic [RecentBits-1:0]      rsp_recent_count,
   output logic [TotalBits-1:0]       rsp_total_count,
   output logic                       rsp_observe_mode,
   output logic [WakeBits-1:0]        rsp_wake_frames,
   // Configuration
   input  wire logic                  csr_write_enable,
   input  wire logic [WakeBits-1:0]   csr_write_data
);

   // State memory and its valid bits.
   entry_type                 mem_ff [FaultKinds];
   logic [FaultKinds-1:0]     vld_ff;

   // Control registers.
   logic [TimeBits-1:0]       tick_time_ff;
   logic                      observe_ff;
   logic [WakeBits-1:0]       wake_ff;
   logic                      s1_vld_ff;
   logic                      rsp_vld_ff;

   // Update stage payload.
   logic [KindBits-1:0]       s1_kind_ff;
   logic [TimeBits-1:0]       s1_time_ff;
   entry_type                 rd_ff;
   logic                      rd_vld_ff;

   // Response payload.
   logic [KindBits-1:0]       rsp_kind_ff;
   action_type                rsp_act_ff;
   logic [RecentBits-1:0]     rsp_recent_ff;
   logic [TotalBits-1:0]      rsp_total_ff;
   logic                      rsp_obs_ff;
   logic [WakeBits-1:0]       rsp_wake_ff;

   // Combinational signals.
   logic                      req_accept;
   logic                      raise_in_range;
   logic                      s1_adv;
   entry_type                 cur_entry;
   entry_type                 new_entry;
   rule_type                  rule;
   logic [TimeBits-1:0]       elapsed;
   logic                      restart;
   logic [RecentBits-1:0]     recent_base;
   logic                      observe_in;

   // Handshake control: the update stage moves on whenever the response
   // register is free or is being emptied in this cycle.
   assign s1_adv         = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall      = s1_vld_ff && !s1_adv;
   assign req_accept     = req_valid && !req_stall;
   assign raise_in_range = (req_type == REQ_RAISE) &&
                           (req_fault_id < KindBits'(FaultKinds));

   // Entry update: window restart, saturating counts and action choice.
   always_comb begin
      cur_entry   = rd_vld_ff ? rd_ff : '0;
      rule        = rule_lookup(s1_kind_ff);
      elapsed     = s1_time_ff - cur_entry.window_start;
      restart     = (rule.window != '0) && (elapsed > TimeBits'(rule.window));
      recent_base = restart ? '0 : cur_entry.recent;
      new_entry   = cur_entry;
      if (restart) begin
         new_entry.window_start = s1_time_ff;
      end
      new_entry.recent = (recent_base == '1) ? recent_base : recent_base + 1'b1;
      new_entry.total  = (cur_entry.total == '1) ? cur_entry.total
                                                 : cur_entry.total + 1'b1;
      if ((rule.threshold != '0) && (new_entry.recent >= rule.threshold)) begin
         new_entry.last_action = rule.escalated;
      end else begin
         new_entry.last_action = rule.first;
      end
      observe_in = observe_ff || (new_entry.last_action == ACT_OBSERVE);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_time_ff <= '0;
         observe_ff   <= 1'b0;
         wake_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            wake_ff <= csr_write_data;
         end
         if (req_accept && (req_type == REQ_TICK)) begin
            tick_time_ff <= tick_time_ff + 1'b1;
         end
         if (s1_adv) begin
            observe_ff           <= observe_in;
            vld_ff[s1_kind_ff]   <= 1'b1;
         end
         if (req_accept) begin
            s1_vld_ff <= raise_in_range;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // State memory: write-back from the update stage, registered read on
   // acceptance with the write data forwarded when both hit the same entry.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem_ff[s1_kind_ff] <= new_entry;
      end
      if (req_accept && raise_in_range) begin
         s1_kind_ff <= req_fault_id;
         s1_time_ff <= tick_time_ff;
         if (s1_adv && (s1_kind_ff == req_fault_id)) begin
            rd_ff     <= new_entry;
            rd_vld_ff <= 1'b1;
         end else begin
            rd_ff     <= mem_ff[req_fault_id];
            rd_vld_ff <= vld_ff[req_fault_id];
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kind_ff   <= s1_kind_ff;
         rsp_act_ff    <= new_entry.last_action;
         rsp_recent_ff <= new_entry.recent;
         rsp_total_ff  <= new_entry.total;
         rsp_obs_ff    <= observe_in;
         rsp_wake_ff   <= wake_ff;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_fault_kind   = rsp_kind_ff;
   assign rsp_action       = 3'(rsp_act_ff);
   assign rsp_recent_count = rsp_recent_ff;
   assign rsp_total_count  = rsp_total_ff;
   assign rsp_observe_mode = rsp_obs_ff;
   assign rsp_wake_frames  = rsp_wake_ff;

   // Checks on the escalation logic.
   `FRE_ASSERT_NEXT(a_unknown_kind_dropped, req_accept && (req_type == REQ_RAISE) && (req_fault_id >= KindBits'(FaultKinds)), !s1_vld_ff, "raise of unknown kind entered the update stage")
   `FRE_ASSERT_NEXT(a_tick_advances_time, req_accept && (req_type == REQ_TICK), tick_time_ff == TimeBits'($past(tick_time_ff) + 1'b1), "tick beat did not advance time")
   `FRE_ASSERT_NEXT(a_observe_sticky, observe_ff, observe_ff, "observe flag cleared outside reset")
   `FRE_ASSERT_NOW(a_counts_consistent, rsp_vld_ff, (rsp_recent_ff != '0) && (TotalBits'(rsp_recent_ff) <= rsp_total_ff), "response counts are inconsistent")
   `FRE_ASSERT_NOW(a_observe_reported, rsp_vld_ff && (rsp_act_ff == ACT_OBSERVE), rsp_obs_ff, "observe action without observe flag")

endmodule

`default_nettype wire
